[sv/plnl_pkg.sv]
// Package for the prefixed number literal lexer.
// Holds result codes, the character class record and shared constants.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package plnl_pkg;

    // Default width of the parsed value.
    localparam int VALUE_WIDTH_DEF = 64;

    // Characters the classifier looks for (upper-case bounds before, the rest after case folding).
    localparam logic [7:0] CH_LPAREN   = 8'h28;  // '('
    localparam logic [7:0] CH_RPAREN   = 8'h29;  // ')'
    localparam logic [7:0] CH_DASH     = 8'h2D;  // '-'
    localparam logic [7:0] CH_ZERO     = 8'h30;  // '0'
    localparam logic [7:0] CH_ONE      = 8'd49;  // '1'
    localparam logic [7:0] CH_SEVEN    = 8'h37;  // '7'
    localparam logic [7:0] CH_NINE     = 8'd57;  // '9'
    localparam logic [7:0] CH_LOWER_A  = 8'h61;  // 'a'
    localparam logic [7:0] CH_LOWER_B  = 8'h62;  // 'b'
    localparam logic [7:0] CH_LOWER_F  = 8'h66;  // 'f'
    localparam logic [7:0] CH_LOWER_X  = 8'h78;  // 'x'
    localparam logic [7:0] CH_UPPER_A  = 8'h41;  // 'A'
    localparam logic [7:0] CH_UPPER_Z  = 8'h5A;  // 'Z'
    localparam logic [7:0] CH_SPACE    = 8'h20;
    localparam logic [7:0] CH_TAB      = 8'h09;
    localparam logic [7:0] CH_CR       = 8'h0D;
    localparam logic [7:0] CASE_OFFSET = 8'h20;

    typedef enum logic [1:0] {
        KIND_NUMBER  = 2'd0,
        KIND_LPAREN  = 2'd1,
        KIND_RPAREN  = 2'd2,
        KIND_UNCLASS = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_INVALID  = 2'd1,
        STATUS_OVERFLOW = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        RADIX_BIN = 2'd0,
        RADIX_OCT = 2'd1,
        RADIX_DEC = 2'd2,
        RADIX_HEX = 2'd3
    } t_radix;

    // One classified character, as passed from front to back.
    typedef struct packed {
        logic       is_ws;      // space or 9..13
        logic       is_dash;
        logic       is_zero;
        logic       is_dec_nz;  // 1..9
        logic       is_oct;     // 0..7
        logic       is_lparen;
        logic       is_rparen;
        logic       is_b;
        logic       is_x;
        logic       is_hex;     // 0..9 or a..f
        logic [3:0] digit;      // digit value when is_hex
        logic       last;
    } t_char_class;

endpackage

`default_nettype wire

[sv/plnl_in_if.sv]
// Character input channel of the lexer: one character and its end mark.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface plnl_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

`default_nettype wire

[sv/plnl_out_if.sv]
// Result channel of the lexer: kind, status, base and parsed value.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface plnl_out_if #(
    parameter int VALUE_WIDTH = 64
);
    logic                   valid;
    logic                   ready;
    logic [1:0]             kind;
    logic [1:0]             status;
    logic [1:0]             base_code;
    logic [VALUE_WIDTH-1:0] value;

    modport source (output valid, output kind, output status, output base_code,
                    output value, input ready);
    modport sink   (input valid, input kind, input status, input base_code,
                    input value, output ready);
endinterface

`default_nettype wire

[sv/prefixed_number_literal_lexer.sv]
// Top level of the prefixed number literal lexer: front, queue and back.
// Depends on plnl_pkg, plnl_in_if, plnl_out_if, plnl_front, plnl_fifo, plnl_back.
//
//   channel  dir  payload                          request
//   i_in     in   ch[7:0], last                    one character of a token
//   o_res    out  kind, status, base_code, value   one result per token
//
// One character per cycle, unless a full result slot holds the back end; the token's result
// is registered when the back end takes its last character from the queue.
// The back end's digit step (shift-add plus overflow guard) is combinational.
// Reset is synchronous.
// A stalled result holds in its register; characters that end no token keep
// flowing, and a two-entry queue absorbs the rest before i_in.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module prefixed_number_literal_lexer #(
    parameter int VALUE_WIDTH = plnl_pkg::VALUE_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    plnl_in_if.sink     i_in,
    plnl_out_if.source  o_res
);
    import plnl_pkg::*;

    logic        w_push_valid;
    logic        w_push_ready;
    t_char_class w_push_data;
    logic        w_pop_valid;
    logic        w_pop_ready;
    t_char_class w_pop_data;

    // Classify incoming characters
    plnl_front u_front (
        .i_in         (i_in),
        .o_push_valid (w_push_valid),
        .i_push_ready (w_push_ready),
        .o_push_data  (w_push_data)
    );

    // Decouple classification from token processing
    plnl_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (w_push_valid),
        .o_push_ready (w_push_ready),
        .i_push_data  (w_push_data),
        .o_pop_valid  (w_pop_valid),
        .i_pop_ready  (w_pop_ready),
        .o_pop_data   (w_pop_data)
    );

    // Token state machine and result
    plnl_back #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_pop_valid),
        .o_ready (w_pop_ready),
        .i_cls   (w_pop_data),
        .o_res   (o_res)
    );

endmodule

`default_nettype wire

[sv/plnl_front.sv]
// Front end of the lexer: accepts characters, folds case and classifies them.
// Depends on plnl_pkg and plnl_in_if.
`timescale 1ns / 1ps
`default_nettype none

module plnl_front (
    plnl_in_if.sink                 i_in,
    output logic                    o_push_valid,
    input  logic                    i_push_ready,
    output plnl_pkg::t_char_class   o_push_data
);
    import plnl_pkg::*;

    logic [7:0] w_ch;

    // Characters pass straight on; the queue decides acceptance
    assign o_push_valid = i_in.valid;
    assign i_in.ready   = i_push_ready;

    // Fold upper case to lower case
    always_comb begin
        w_ch = i_in.ch;
        if (i_in.ch >= CH_UPPER_A && i_in.ch <= CH_UPPER_Z) begin
            w_ch = i_in.ch + CASE_OFFSET;
        end
    end

    // Classify the folded character
    always_comb begin
        o_push_data           = '0;
        o_push_data.is_ws     = (w_ch == CH_SPACE) || (w_ch >= CH_TAB && w_ch <= CH_CR);
        o_push_data.is_dash   = (w_ch == CH_DASH);
        o_push_data.is_zero   = (w_ch == CH_ZERO);
        o_push_data.is_dec_nz = (w_ch >= CH_ONE) && (w_ch <= CH_NINE);
        o_push_data.is_oct    = (w_ch >= CH_ZERO) && (w_ch <= CH_SEVEN);
        o_push_data.is_lparen = (w_ch == CH_LPAREN);
        o_push_data.is_rparen = (w_ch == CH_RPAREN);
        o_push_data.is_b      = (w_ch == CH_LOWER_B);
        o_push_data.is_x      = (w_ch == CH_LOWER_X);
        o_push_data.last      = i_in.last;
        if (w_ch >= CH_ZERO && w_ch <= CH_NINE) begin
            o_push_data.is_hex = 1'b1;
            o_push_data.digit  = 4'(w_ch - CH_ZERO);
        end else if (w_ch >= CH_LOWER_A && w_ch <= CH_LOWER_F) begin
            o_push_data.is_hex = 1'b1;
            o_push_data.digit  = 4'(w_ch - CH_LOWER_A + 8'd10);
        end
    end

endmodule

`default_nettype wire

[sv/plnl_fifo.sv]
// Two-entry queue of classified characters between front and back.
// Depends on plnl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module plnl_fifo (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push_valid,
    output logic                    o_push_ready,
    input  plnl_pkg::t_char_class   i_push_data,
    output logic                    o_pop_valid,
    input  logic                    i_pop_ready,
    output plnl_pkg::t_char_class   o_pop_data
);
    import plnl_pkg::*;

    t_char_class r_mem [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        w_push;
    logic        w_pop;

    assign o_push_ready = (r_count != 2'd2);
    assign o_pop_valid  = (r_count != 2'd0);
    assign o_pop_data   = r_mem[r_rd_ptr];
    assign w_push       = i_push_valid && o_push_ready;
    assign w_pop        = o_pop_valid && i_pop_ready;

    // Storage, no reset needed
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

`default_nettype wire

[sv/plnl_back.sv]
// Back end of the lexer: token state machine, digit accumulator, result register.
// Depends on plnl_pkg and plnl_out_if.
`timescale 1ns / 1ps
`default_nettype none

module plnl_back #(
    parameter int VALUE_WIDTH = plnl_pkg::VALUE_WIDTH_DEF
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_ready,
    input  plnl_pkg::t_char_class   i_cls,
    plnl_out_if.source              o_res
);
    import plnl_pkg::*;

    localparam int WIDE = VALUE_WIDTH + 4;

    typedef enum logic [2:0] {
        PH_START,
        PH_LEADWS,
        PH_ZERO,
        PH_PREFIX,
        PH_DIGITS,
        PH_TRAIL,
        PH_PAREN,
        PH_BAD
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    t_radix                 r_radix, n_radix;
    logic                   r_ovf, n_ovf;
    logic                   r_dash, n_dash;
    logic                   r_paren_right, n_paren_right;

    logic                   r_out_valid;
    t_kind                  r_kind, n_kind;
    t_status                r_status, n_status;
    t_radix                 r_base, n_base;
    logic [VALUE_WIDTH-1:0] r_value, n_value;

    logic                   w_take;
    logic [3:0]             w_digit;
    logic                   w_in_radix;
    logic [WIDE-1:0]        w_scaled;
    logic [WIDE-1:0]        w_wide;
    logic                   w_pop;

    // A character moves on unless it ends a token and the result slot is full and not being taken
    assign o_ready = !i_cls.last || !r_out_valid || o_res.ready;
    assign w_pop   = i_valid && o_ready;

    assign o_res.valid     = r_out_valid;
    assign o_res.kind      = r_kind;
    assign o_res.status    = r_status;
    assign o_res.base_code = r_base;
    assign o_res.value     = r_value;

    // Is the character a digit of the current radix
    always_comb begin
        case (r_radix)
            RADIX_BIN: w_in_radix = i_cls.is_hex && (i_cls.digit < 4'd2);
            RADIX_OCT: w_in_radix = i_cls.is_hex && (i_cls.digit < 4'd8);
            RADIX_DEC: w_in_radix = i_cls.is_hex && (i_cls.digit < 4'd10);
            default:   w_in_radix = i_cls.is_hex;
        endcase
    end

    // Next token state
    always_comb begin
        n_phase       = r_phase;
        n_radix       = r_radix;
        n_paren_right = r_paren_right;
        n_dash        = r_dash || i_cls.is_dash;
        w_take        = 1'b0;
        w_digit       = i_cls.digit;
        case (r_phase)
            PH_START, PH_LEADWS: begin
                if (i_cls.is_ws) begin
                    n_phase = PH_LEADWS;
                end else if (i_cls.is_zero) begin
                    n_radix = RADIX_DEC;
                    w_take  = 1'b1;
                    w_digit = 4'd0;
                    n_phase = PH_ZERO;
                end else if (i_cls.is_dec_nz) begin
                    n_radix = RADIX_DEC;
                    w_take  = 1'b1;
                    n_phase = PH_DIGITS;
                end else if (r_phase == PH_START && i_cls.is_lparen) begin
                    n_paren_right = 1'b0;
                    n_phase       = PH_PAREN;
                end else if (r_phase == PH_START && i_cls.is_rparen) begin
                    n_paren_right = 1'b1;
                    n_phase       = PH_PAREN;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_ZERO: begin
                if (i_cls.is_b) begin
                    n_radix = RADIX_BIN;
                    n_phase = PH_PREFIX;
                end else if (i_cls.is_x) begin
                    n_radix = RADIX_HEX;
                    n_phase = PH_PREFIX;
                end else if (i_cls.is_oct) begin
                    // accumulator is already zero after the leading zero
                    n_radix = RADIX_OCT;
                    w_take  = 1'b1;
                    n_phase = PH_DIGITS;
                end else if (i_cls.is_ws) begin
                    n_phase = PH_TRAIL;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_PREFIX, PH_DIGITS: begin
                if (w_in_radix) begin
                    w_take  = 1'b1;
                    n_phase = PH_DIGITS;
                end else if (r_phase == PH_DIGITS && i_cls.is_ws) begin
                    n_phase = PH_TRAIL;
                end else begin
                    n_phase = PH_BAD;
                end
            end
            PH_TRAIL: begin
                if (!i_cls.is_ws) begin
                    n_phase = PH_BAD;
                end
            end
            default: begin
                n_phase = PH_BAD;
            end
        endcase
    end

    // Multiply by the base with shifts and adds, four guard bits catch overflow
    always_comb begin
        case (n_radix)
            RADIX_BIN: w_scaled = {3'b000, r_acc, 1'b0};
            RADIX_OCT: w_scaled = {1'b0, r_acc, 3'b000};
            RADIX_DEC: w_scaled = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0};
            default:   w_scaled = {r_acc, 4'b0000};
        endcase
        w_wide = w_scaled + WIDE'(w_digit);
    end

    // Accumulator update; overflow sticks and clears the value
    always_comb begin
        n_acc = r_acc;
        n_ovf = r_ovf;
        if (w_take && !r_ovf) begin
            if (w_wide[WIDE-1:VALUE_WIDTH] != 4'd0) begin
                n_ovf = 1'b1;
                n_acc = '0;
            end else begin
                n_acc = w_wide[VALUE_WIDTH-1:0];
            end
        end
    end

    // Result of a token that ends with this character
    always_comb begin
        n_kind   = KIND_UNCLASS;
        n_status = STATUS_INVALID;
        n_base   = RADIX_BIN;
        n_value  = '0;
        if (n_dash) begin
            n_kind = KIND_UNCLASS;
        end else if (n_ovf) begin
            n_kind   = KIND_NUMBER;
            n_status = STATUS_OVERFLOW;
            n_base   = n_radix;
        end else if (n_phase == PH_ZERO || n_phase == PH_DIGITS || n_phase == PH_TRAIL) begin
            n_kind   = KIND_NUMBER;
            n_status = STATUS_OK;
            n_base   = n_radix;
            n_value  = n_acc;
        end else if (n_phase == PH_PAREN) begin
            n_kind   = n_paren_right ? KIND_RPAREN : KIND_LPAREN;
            n_status = STATUS_OK;
        end
    end

    // Token state and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= PH_START;
            r_acc         <= '0;
            r_radix       <= RADIX_BIN;
            r_ovf         <= 1'b0;
            r_dash        <= 1'b0;
            r_paren_right <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            // A new result refills the slot in the cycle the old one leaves
            if (w_pop && i_cls.last) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_res.ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_pop) begin
                if (i_cls.last) begin
                    r_kind        <= n_kind;
                    r_status      <= n_status;
                    r_base        <= n_base;
                    r_value       <= n_value;
                    r_phase       <= PH_START;
                    r_acc         <= '0;
                    r_radix       <= RADIX_BIN;
                    r_ovf         <= 1'b0;
                    r_dash        <= 1'b0;
                    r_paren_right <= 1'b0;
                end else begin
                    r_phase       <= n_phase;
                    r_acc         <= n_acc;
                    r_radix       <= n_radix;
                    r_ovf         <= n_ovf;
                    r_dash        <= n_dash;
                    r_paren_right <= n_paren_right;
                end
            end
        end
    end

endmodule

`default_nettype wire
